// ===== sv/sfr_pkg.sv =====
// sfr_pkg: constants and types shared by the sync frame receiver
// no dependencies; compiled first

package sfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned NUM_VALUES = 3;

  localparam logic [BYTE_W-1:0] FRAME_MARKER = 8'hFF;

  // byte positions inside a frame (marker is position zero)
  localparam logic [POS_W-1:0] POS_ID       = 4'd1;
  localparam logic [POS_W-1:0] POS_CMD      = 4'd2;
  localparam logic [POS_W-1:0] POS_VAL_BASE = 4'd3;
  localparam logic [POS_W-1:0] POS_LAST     = 4'd15;

  typedef struct packed {
    logic [BYTE_W-1:0]         node_id;
    logic [BYTE_W-1:0]         command;
    logic signed [VALUE_W-1:0] value_a;
    logic signed [VALUE_W-1:0] value_b;
    logic signed [VALUE_W-1:0] value_c;
    logic                      checksum_ok;
  } frame_t;

  // handshake between the input stage and the assembler
  typedef struct packed {
    logic take;   // byte in the input register is consumed this cycle
    logic emit;   // consumed byte completes a frame
  } ctl_t;

endpackage

// ===== sv/sfr_if.sv =====
// sfr_if: valid/ready channel interfaces for the byte stream and frame results
// depends on sfr_pkg

interface sfr_byte_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
  logic                                valid;
  logic                                ready;
  logic [sfr_pkg::BYTE_W-1:0]          node_id;
  logic [sfr_pkg::BYTE_W-1:0]          command;
  logic signed [sfr_pkg::VALUE_W-1:0]  value_a;
  logic signed [sfr_pkg::VALUE_W-1:0]  value_b;
  logic signed [sfr_pkg::VALUE_W-1:0]  value_c;
  logic                                checksum_ok;

  modport source (output valid, output node_id, output command, output value_a,
                  output value_b, output value_c, output checksum_ok, input ready);
  modport sink   (input valid, input node_id, input command, input value_a,
                  input value_b, input value_c, input checksum_ok, output ready);
endinterface

// ===== sv/sync_frame_receiver.sv =====
// sync_frame_receiver: top level of the marker-synchronised frame receiver
// depends on sfr_pkg, sfr_if, sfr_in_stage, sfr_assembler, sfr_out_stage
//
//   channel   direction  payload                                    handshake
//   in_ch     sink       rx_byte[7:0]                               valid/ready
//   out_ch    source     node_id, command, value_a/b/c, checksum_ok valid/ready
//
// one byte transfer per cycle sustained while no finished frame waits untaken on out_ch;
//   a frame result is offered on out_ch once its sixteenth byte has passed the
//   input register, then the result register
// reset is synchronous and active low; in_ch.ready stays low during reset and
//   until the registered up_r flag has been set after it
// only a frame-closing byte waits on the result register; every other byte
//   moves on in the cycle after its transfer, so in_ch stalls only while a
//   finished frame sits untaken on out_ch

module sync_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  sfr_byte_if.sink    in_ch,
  sfr_frame_if.source out_ch
);

  logic                       byte_vld;
  logic [sfr_pkg::BYTE_W-1:0] byte_val;
  logic                       out_free;
  sfr_pkg::ctl_t              ctl;
  sfr_pkg::frame_t            frame;

  // input register: parts the byte channel from the frame logic
  sfr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ctl      (ctl),
    .byte_vld (byte_vld),
    .byte_val (byte_val)
  );

  // hunt for the marker, collect fields, keep the wrapping sum
  sfr_assembler u_assembler (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_val (byte_val),
    .out_free (out_free),
    .ctl      (ctl),
    .frame    (frame)
  );

  // result register: holds a finished frame until the consumer takes it
  sfr_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .frame    (frame),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== sv/sfr_in_stage.sv =====
// sfr_in_stage: input register for received bytes
// depends on sfr_pkg and sfr_if

module sfr_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  sfr_byte_if.sink                   in_ch,
  input  sfr_pkg::ctl_t              ctl,
  output logic                       byte_vld,
  output logic [sfr_pkg::BYTE_W-1:0] byte_val
);

  logic                       up_r;
  logic                       vld_r;
  logic [sfr_pkg::BYTE_W-1:0] byte_r;
  logic                       vld_nxt;

  // room when empty or when the held byte moves on
  assign in_ch.ready = up_r && (!vld_r || ctl.take);

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.take) begin
      vld_nxt = 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      up_r  <= 1'b1;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

// ===== sv/sfr_assembler.sv =====
// sfr_assembler: marker hunt, field capture and running checksum
// depends on sfr_pkg

module sfr_assembler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_vld,
  input  logic [sfr_pkg::BYTE_W-1:0] byte_val,
  input  logic                       out_free,
  output sfr_pkg::ctl_t              ctl,
  output sfr_pkg::frame_t            frame
);

  logic                        in_frame_r, in_frame_nxt;
  logic [sfr_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  id_r, id_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic [sfr_pkg::VALUE_W-1:0] val_r   [sfr_pkg::NUM_VALUES];
  logic [sfr_pkg::VALUE_W-1:0] val_nxt [sfr_pkg::NUM_VALUES];
  logic                        is_last;
  logic [sfr_pkg::POS_W-1:0]   off;
  logic [1:0]                  lane;
  logic [4:0]                  shamt;

  assign is_last  = in_frame_r && (pos_r == sfr_pkg::POS_LAST);
  assign ctl.take = byte_vld && (!is_last || out_free);
  assign ctl.emit = ctl.take && is_last;

  assign off   = pos_r - sfr_pkg::POS_VAL_BASE;
  assign lane  = off[3:2];
  assign shamt = {off[1:0], 3'b000};

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    id_nxt       = id_r;
    cmd_nxt      = cmd_r;
    val_nxt      = val_r;
    if (ctl.take) begin
      if (!in_frame_r) begin
        if (byte_val == sfr_pkg::FRAME_MARKER) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = sfr_pkg::POS_ID;
          sum_nxt      = sfr_pkg::FRAME_MARKER;
          id_nxt       = '0;
          cmd_nxt      = '0;
          for (int i = 0; i < sfr_pkg::NUM_VALUES; i++) begin
            val_nxt[i] = '0;
          end
        end
      end else if (is_last) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        sum_nxt      = '0;
      end else begin
        if (pos_r == sfr_pkg::POS_ID) begin
          id_nxt = byte_val;
        end else if (pos_r == sfr_pkg::POS_CMD) begin
          cmd_nxt = byte_val;
        end else begin
          for (int i = 0; i < sfr_pkg::NUM_VALUES; i++) begin
            if (lane == 2'(i)) begin
              val_nxt[i] = val_r[i]
                         | (sfr_pkg::VALUE_W'(byte_val) << shamt);
            end
          end
        end
        sum_nxt = sum_r + byte_val;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
    end
  end

  // field registers are always cleared by the marker before use
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
  end

  assign frame.node_id     = id_r;
  assign frame.command     = cmd_r;
  assign frame.value_a     = val_r[0];
  assign frame.value_b     = val_r[1];
  assign frame.value_c     = val_r[2];
  assign frame.checksum_ok = (byte_val == sum_r);

endmodule

// ===== sv/sfr_out_stage.sv =====
// sfr_out_stage: result register driving the frame channel
// depends on sfr_pkg and sfr_if

module sfr_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  sfr_pkg::ctl_t   ctl,
  input  sfr_pkg::frame_t frame,
  output logic            out_free,
  sfr_frame_if.source     out_ch
);

  logic            vld_r;
  sfr_pkg::frame_t frame_r;

  assign out_free = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.emit) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      frame_r <= frame;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.node_id     = frame_r.node_id;
  assign out_ch.command     = frame_r.command;
  assign out_ch.value_a     = frame_r.value_a;
  assign out_ch.value_b     = frame_r.value_b;
  assign out_ch.value_c     = frame_r.value_c;
  assign out_ch.checksum_ok = frame_r.checksum_ok;

endmodule

// ===== sv/sfr_checker.sv =====
// sfr_checker: port-level checks for sync_frame_receiver, bound to the top
// depends on sfr_pkg and sync_frame_receiver

module sfr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sfr_pkg::BYTE_W-1:0]        node_id,
  input logic [sfr_pkg::BYTE_W-1:0]        command,
  input logic signed [sfr_pkg::VALUE_W-1:0] value_a,
  input logic signed [sfr_pkg::VALUE_W-1:0] value_b,
  input logic signed [sfr_pkg::VALUE_W-1:0] value_c,
  input logic                              checksum_ok
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(node_id) && $stable(command)
      && $stable(value_a) && $stable(value_b) && $stable(value_c)
      && $stable(checksum_ok))
    else $error("result payload changed while stalled");

  // the byte side only stalls behind an untaken result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_ready |-> out_valid && !out_ready)
    else $error("byte channel stalled without a pending result");

  // a fresh result follows a byte transfer, through the input and result registers
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a closing byte transfer");

endmodule

bind sync_frame_receiver sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .node_id     (out_ch.node_id),
  .command     (out_ch.command),
  .value_a     (out_ch.value_a),
  .value_b     (out_ch.value_b),
  .value_c     (out_ch.value_c),
  .checksum_ok (out_ch.checksum_ok)
);

// ===== verif/tb_sync_frame_receiver.sv =====
// tb_sync_frame_receiver: self-checking bench for the marker-synchronised frame receiver
// depends on sfr_pkg, sfr_if and the sync_frame_receiver rtl
// byte stream in, frames out; every frame checked against a cycle-free frame assembler or a hand-typed row

module tb_sync_frame_receiver;

  // checksum byte handling when a frame is built
  typedef enum logic [1:0] {CSUM_GOOD, CSUM_BAD, CSUM_RAW} csum_mode_t;

  typedef logic [sfr_pkg::BYTE_W-1:0] frame_bytes_t [16];

  // one row of the directed table: a frame, optionally preceded by hunting noise
  typedef struct {
    int unsigned                 noise_len;
    logic [sfr_pkg::BYTE_W-1:0]  id;
    logic [sfr_pkg::BYTE_W-1:0]  cmd;
    logic [sfr_pkg::VALUE_W-1:0] va;
    logic [sfr_pkg::VALUE_W-1:0] vb;
    logic [sfr_pkg::VALUE_W-1:0] vc;
    csum_mode_t                  mode;
    logic [sfr_pkg::BYTE_W-1:0]  raw_sum;
    bit                          typed;
    sfr_pkg::frame_t             want;
  } frame_row_t;

  logic clk;
  logic rst_n;

  sfr_byte_if  byte_ch ();
  sfr_frame_if frame_ch ();

  sync_frame_receiver DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (frame_ch)
  );

  // assembler state, mirrors what the receiver keeps between bytes
  logic [sfr_pkg::POS_W-1:0]   asm_pos;
  logic                        asm_in_frame;
  logic [sfr_pkg::BYTE_W-1:0]  asm_sum;
  logic [sfr_pkg::BYTE_W-1:0]  asm_id;
  logic [sfr_pkg::BYTE_W-1:0]  asm_cmd;
  logic [sfr_pkg::VALUE_W-1:0] asm_vals [sfr_pkg::NUM_VALUES];

  sfr_pkg::frame_t pending_frames [$];

  // a directed row may replace the assembler's frame with a hand-typed one
  bit              typed_armed;
  sfr_pkg::frame_t typed_frame;

  int unsigned bytes_sent;
  int unsigned frames_checked;
  int unsigned bad_sum_frames;
  int unsigned mismatches;

  // bytes dropped while hunting in the directed part
  logic [sfr_pkg::BYTE_W-1:0] hunt_noise [5] = '{8'h00, 8'hFE, 8'h7F, 8'h80, 8'h01};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("timeout: %0d frames still expected", pending_frames.size());
    $display("** sync_frame_receiver: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // feed one accepted byte into the assembler; returns 1 when a frame closes
  function automatic bit absorb_byte(input logic [sfr_pkg::BYTE_W-1:0] b,
                                     output sfr_pkg::frame_t f);
    int unsigned off;
    f = '0;
    // hunting: only the marker opens a frame, with everything held cleared
    if (!asm_in_frame) begin
      if (b == sfr_pkg::FRAME_MARKER) begin
        asm_in_frame = 1'b1;
        asm_pos      = sfr_pkg::POS_ID;
        asm_sum      = sfr_pkg::FRAME_MARKER;
        asm_id       = '0;
        asm_cmd      = '0;
        for (int i = 0; i < sfr_pkg::NUM_VALUES; i++) asm_vals[i] = '0;
      end
      return 1'b0;
    end
    // sixteenth byte: checksum compare, emit, back to hunting
    if (asm_pos == sfr_pkg::POS_LAST) begin
      f.node_id     = asm_id;
      f.command     = asm_cmd;
      f.value_a     = asm_vals[0];
      f.value_b     = asm_vals[1];
      f.value_c     = asm_vals[2];
      f.checksum_ok = (b == asm_sum);
      asm_in_frame  = 1'b0;
      asm_pos       = '0;
      asm_sum       = '0;
      return 1'b1;
    end
    // a marker inside a frame is plain data, no resync
    if (asm_pos == sfr_pkg::POS_ID) begin
      asm_id = b;
    end else if (asm_pos == sfr_pkg::POS_CMD) begin
      asm_cmd = b;
    end else begin
      off = asm_pos - sfr_pkg::POS_VAL_BASE;
      asm_vals[off / 4][(off % 4) * 8 +: 8] = b;   // little endian
    end
    asm_sum = asm_sum + b;
    asm_pos = asm_pos + 1'b1;
    return 1'b0;
  endfunction

  // marker, fields little endian, checksum as the mode asks
  function automatic frame_bytes_t build_frame(input logic [sfr_pkg::BYTE_W-1:0] id,
      input logic [sfr_pkg::BYTE_W-1:0] cmd, input logic [sfr_pkg::VALUE_W-1:0] va,
      input logic [sfr_pkg::VALUE_W-1:0] vb, input logic [sfr_pkg::VALUE_W-1:0] vc,
      input csum_mode_t mode, input logic [sfr_pkg::BYTE_W-1:0] raw_sum);
    frame_bytes_t fb;
    logic [sfr_pkg::BYTE_W-1:0] sum;
    fb[0] = sfr_pkg::FRAME_MARKER;
    fb[1] = id;
    fb[2] = cmd;
    for (int k = 0; k < 4; k++) begin
      fb[3 + k]  = va[k*8 +: 8];
      fb[7 + k]  = vb[k*8 +: 8];
      fb[11 + k] = vc[k*8 +: 8];
    end
    sum = '0;
    for (int k = 0; k < 15; k++) sum = sum + fb[k];
    case (mode)
      CSUM_GOOD: fb[15] = sum;
      CSUM_BAD:  fb[15] = sum + 8'd1;
      default:   fb[15] = raw_sum;
    endcase
    return fb;
  endfunction

  // source gap: none in quiet stretches, otherwise mostly short with a few long
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // field values lean towards the extremes of a signed 32-bit count
  function automatic logic [sfr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sfr_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return sfr_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input int unsigned gap);
    sfr_pkg::frame_t f;
    if (gap != 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.rx_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    if (absorb_byte(b, f)) begin
      pending_frames.push_back(typed_armed ? typed_frame : f);
      typed_armed = 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_bytes_t fb, input bit quiet);
    for (int k = 0; k < 16; k++) send_byte(fb[k], pick_gap(quiet));
  endtask

  // result side: random ready, every frame transfer checked against the oldest expectation
  initial begin : frame_sink
    int unsigned     hold;
    int unsigned     r;
    sfr_pkg::frame_t got;
    sfr_pkg::frame_t want;
    hold           = 0;
    frame_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          frame_ch.ready = 1'b1;          // long stretch with no stall
          hold = $urandom_range(50, 150);
        end else if (r < 55) begin
          frame_ch.ready = 1'b1;
          hold = $urandom_range(1, 8);
        end else if (r < 95) begin
          frame_ch.ready = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          frame_ch.ready = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
      hold--;
      @(posedge clk);
      if (frame_ch.valid && frame_ch.ready) begin
        got.node_id     = frame_ch.node_id;
        got.command     = frame_ch.command;
        got.value_a     = frame_ch.value_a;
        got.value_b     = frame_ch.value_b;
        got.value_c     = frame_ch.value_c;
        got.checksum_ok = frame_ch.checksum_ok;
        if (!got.checksum_ok) bad_sum_frames++;
        if (pending_frames.size() == 0) begin
          report_mismatch($sformatf("frame with nothing expected, node_id %0h command %0h",
                                    got.node_id, got.command));
        end else begin
          want = pending_frames.pop_front();
          if (got.node_id !== want.node_id)
            report_mismatch($sformatf("frame %0d node_id %0h, expected %0h",
                                      frames_checked, got.node_id, want.node_id));
          if (got.command !== want.command)
            report_mismatch($sformatf("frame %0d command %0h, expected %0h",
                                      frames_checked, got.command, want.command));
          if (got.value_a !== want.value_a)
            report_mismatch($sformatf("frame %0d value_a %0d, expected %0d",
                                      frames_checked, got.value_a, want.value_a));
          if (got.value_b !== want.value_b)
            report_mismatch($sformatf("frame %0d value_b %0d, expected %0d",
                                      frames_checked, got.value_b, want.value_b));
          if (got.value_c !== want.value_c)
            report_mismatch($sformatf("frame %0d value_c %0d, expected %0d",
                                      frames_checked, got.value_c, want.value_c));
          if (got.checksum_ok !== want.checksum_ok)
            report_mismatch($sformatf("frame %0d checksum_ok %0b, expected %0b",
                                      frames_checked, got.checksum_ok, want.checksum_ok));
          frames_checked++;
        end
      end
    end
  end

  // byte side: reset, directed table, then random frames, noise and broken frames
  initial begin : byte_source
    frame_row_t   rows [5];
    frame_bytes_t fb;
    bit           quiet;
    int unsigned  r;
    int unsigned  cut;
    int unsigned  settle;

    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    typed_armed     = 1'b0;
    typed_frame     = '0;
    bytes_sent      = 0;
    frames_checked  = 0;
    bad_sum_frames  = 0;
    mismatches      = 0;
    asm_pos         = '0;
    asm_in_frame    = 1'b0;
    asm_sum         = '0;
    asm_id          = '0;
    asm_cmd         = '0;
    for (int i = 0; i < sfr_pkg::NUM_VALUES; i++) asm_vals[i] = '0;

    // noise, id, cmd, values, checksum handling, typed expectation
    rows = '{
      // hunting noise then an all-zero frame
      '{5, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, CSUM_GOOD, 8'h00,
        1'b1, '{8'h00, 8'h00, 32'sh0, 32'sh0, 32'sh0, 1'b1}},
      // field extremes, with no noise between it and the previous frame
      '{0, 8'hFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, CSUM_GOOD, 8'h00,
        1'b1, '{8'hFF, 8'hFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 1'b1}},
      // checksum off by one: frame still comes out, flagged
      '{0, 8'h5A, 8'hA5, 32'h1, 32'h2, 32'h3, CSUM_BAD, 8'h00,
        1'b1, '{8'h5A, 8'hA5, 32'sh1, 32'sh2, 32'sh3, 1'b0}},
      // marker bytes used as data inside the frame, marker as checksum byte
      '{1, 8'hFF, 8'h01, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h0000_00FF, CSUM_RAW, 8'hFF,
        1'b0, '0},
      '{0, 8'h12, 8'h34, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, CSUM_GOOD, 8'h00,
        1'b0, '0}
    };

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].noise_len; k++) send_byte(hunt_noise[k % 5], pick_gap(1'b0));
      typed_armed = rows[i].typed;
      typed_frame = rows[i].want;
      fb = build_frame(rows[i].id, rows[i].cmd, rows[i].va, rows[i].vb, rows[i].vc,
                       rows[i].mode, rows[i].raw_sum);
      send_frame(fb, 1'b0);
    end

    // random part: mostly good frames with random content
    while (bytes_sent < 750) begin
      quiet = ($urandom_range(0, 4) == 0);
      r     = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 4))
            send_byte(sfr_pkg::BYTE_W'($urandom_range(0, 254)), pick_gap(quiet));
        fb = build_frame(pick_byte(), pick_byte(), pick_value(), pick_value(), pick_value(),
                         ($urandom_range(0, 3) == 0) ? CSUM_RAW : CSUM_GOOD,
                         sfr_pkg::BYTE_W'($urandom_range(0, 255)));
        send_frame(fb, quiet);
      end else if (r < 85) begin
        // frame cut short; whatever follows is taken as its remaining bytes
        fb  = build_frame(pick_byte(), pick_byte(), pick_value(), pick_value(), pick_value(),
                          CSUM_GOOD, 8'h00);
        cut = $urandom_range(1, 15);
        for (int k = 0; k < cut; k++) send_byte(fb[k], pick_gap(quiet));
      end else begin
        // line noise, marker included
        repeat ($urandom_range(1, 6))
          send_byte(sfr_pkg::BYTE_W'($urandom_range(0, 255)), pick_gap(quiet));
      end
    end

    byte_ch.valid = 1'b0;

    // drain, then settle for anything stray; the timeout guards the wait
    while (pending_frames.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 16) begin
      @(posedge clk);
      settle++;
    end

    if (pending_frames.size() != 0)
      report_mismatch($sformatf("%0d frames never arrived", pending_frames.size()));

    $display("%0d byte transfers driven, %0d frames checked", bytes_sent, frames_checked);
    $display("%0d frames carried a bad checksum flag, %0d mismatches",
             bad_sum_frames, mismatches);
    if (mismatches == 0) begin
      $display("** sync_frame_receiver: PASSED **");
    end else begin
      $display("** sync_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sfr_pkg.sv
sv/sfr_if.sv
sv/sfr_in_stage.sv
sv/sfr_assembler.sv
sv/sfr_out_stage.sv
sv/sync_frame_receiver.sv
sv/sfr_checker.sv
verif/tb_sync_frame_receiver.sv
